### sv/dot_matrix_scroll_animator_defines.svh
// Assertion macros shared by the scroll animator RTL.
// Needs a clk_i and an active-low rst_ni in the module that uses them.
`ifndef DOT_MATRIX_SCROLL_ANIMATOR_DEFINES_SVH
`define DOT_MATRIX_SCROLL_ANIMATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define DMSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only.
`define DMSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dmsa_pkg.sv
// Shared types and default sizes of the dot-matrix scroll animator.
// No dependencies; the top module and the bench import it.
`timescale 1ns / 1ps

package dmsa_pkg;

  localparam int FRAME_ROWS_DEF  = 160;
  localparam int ROW_WORDS_DEF   = 5;
  localparam int MARGIN_ROWS_DEF = 16;
  localparam int STEP_ROWS_DEF   = 4;

  typedef enum logic [1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_START   = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_READ_B  = 2'd3
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [9:0]  word_index;
    logic [31:0] word_data;
    logic        cyclic_display;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic [2:0]  mix_mode;
    logic        timer_load_valid;
    logic [7:0]  timer_load;
    logic [1:0]  anim_state;
    logic [7:0]  frame_count;
  } out_item_t;

endpackage

### sv/dmsa_stream_if.sv
// Valid/ready channel carrying one payload struct per transfer.
// The payload type is bound where the channel is instantiated (see dmsa_pkg).
`timescale 1ns / 1ps

interface dmsa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/dot_matrix_scroll_animator.sv
// Channel   Dir  Payload      Transfer when
// in_i      in   in_item_t    in_i.valid & in_i.ready
// out_o     out  out_item_t   out_o.valid & out_o.ready
// apb       in   anim_mode, frame_delay at 0x0, 0x4   psel & penable & pwrite
//
// Write, start and no-op ticks finish when taken; a B read goes via SEQ_READ.
// The load tick after a start copies A into B one word a cycle over A's read
// port and B's write port.
// An up or down scroll tick moves the band through B's read and write ports,
// one word a cycle. No clearing pass.
// A B read loads the result register in SEQ_READ, any other item when it is
// taken; a stalled output holds it and blocks the next item only until sent.
// Depends on dmsa_pkg, dmsa_stream_if, dmsa_ram and the defines header.
`timescale 1ns / 1ps
`include "dot_matrix_scroll_animator_defines.svh"

module dot_matrix_scroll_animator #(
  parameter int FRAME_ROWS  = dmsa_pkg::FRAME_ROWS_DEF,
  parameter int ROW_WORDS   = dmsa_pkg::ROW_WORDS_DEF,
  parameter int MARGIN_ROWS = dmsa_pkg::MARGIN_ROWS_DEF,
  parameter int STEP_ROWS   = dmsa_pkg::STEP_ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dmsa_stream_if.sink          in_i,
  dmsa_stream_if.source        out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import dmsa_pkg::*;

  localparam int BUF_WORDS  = FRAME_ROWS * ROW_WORDS;
  localparam int AW         = $clog2(BUF_WORDS);
  localparam int XW         = AW + 1;
  localparam int BAND_ROWS  = (FRAME_ROWS > 2 * MARGIN_ROWS) ?
                              FRAME_ROWS - 2 * MARGIN_ROWS : 0;
  localparam int BAND_WORDS = BAND_ROWS * ROW_WORDS;
  localparam int BAND_LAST  = (BAND_WORDS > 0) ? BAND_WORDS - 1 : 0;
  localparam int BASE_WORD  = MARGIN_ROWS * ROW_WORDS;
  localparam int STEP_WORDS = STEP_ROWS * ROW_WORDS;

  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_DOWN  = 3'd1;
  localparam logic [2:0] MODE_UP    = 3'd2;
  localparam logic [2:0] MODE_LEFT  = 3'd3;
  localparam logic [2:0] MODE_RIGHT = 3'd4;

  localparam logic [2:0] MIX_A = 3'd0;
  localparam logic [2:0] MIX_B = 3'd1;

  typedef enum logic {
    REG_ANIM_MODE   = 1'b0,
    REG_FRAME_DELAY = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    TASK_IDLE    = 2'd0,
    TASK_PENDING = 2'd1,
    TASK_PLAYING = 2'd2
  } task_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_READ,
    SEQ_COPY,
    SEQ_SCROLL
  } seq_e;

  // Registers
  seq_e        seq_q, seq_d;
  task_e       task_q, task_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [2:0]  mix_q, mix_d;
  logic [2:0]  mode_q, mode_d;
  logic [7:0]  delay_q, delay_d;
  logic [AW-1:0] off_q, off_d;
  logic        down_q, down_d;
  logic        rd_ok_q, rd_ok_d;
  logic        wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic        wr_zero_q, wr_zero_d;
  logic        wr_from_a_q, wr_from_a_d;
  logic        ov_q, ov_d;
  out_item_t   out_q, out_d;

  // Combinational
  logic          in_ready;
  logic          accept;
  logic [AW+9:0] idx_ext;
  logic          idx_ok;
  logic [AW-1:0] idx_addr;
  logic [8:0]    cnt_sum;
  logic [XW-1:0] band_off;
  logic [XW-1:0] dst_word;
  logic [XW-1:0] src_word;
  logic          copy_ok;
  logic          load_res;
  logic          tv;
  logic [7:0]    tl;
  logic          cfg_we;

  logic          a_we;
  logic [AW-1:0] a_raddr;
  logic [31:0]   a_rdata;
  logic          b_we;
  logic [AW-1:0] b_raddr;
  logic [31:0]   b_rdata;
  logic [31:0]   b_wdata;

  dmsa_ram #(.WIDTH(32), .DEPTH(BUF_WORDS)) u_buf_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (idx_addr),
    .wdata_i (in_i.payload.word_data),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  dmsa_ram #(.WIDTH(32), .DEPTH(BUF_WORDS)) u_buf_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (wr_addr_q),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign b_we    = wr_pend_q;
  assign b_wdata = wr_zero_q ? 32'd0 : (wr_from_a_q ? a_rdata : b_rdata);

  assign idx_ext  = {{AW{1'b0}}, in_i.payload.word_index};
  assign idx_ok   = idx_ext < (AW + 10)'(BUF_WORDS);
  assign idx_addr = idx_ext[AW-1:0];

  assign cnt_sum = {1'b0, cnt_q} + 9'(STEP_ROWS);

  // Band walk: down runs from the bottom of the band, up from the top
  assign band_off = down_q ? XW'(BAND_LAST) - {1'b0, off_q} : {1'b0, off_q};
  assign dst_word = XW'(BASE_WORD) + band_off;
  assign copy_ok  = down_q ? (band_off >= XW'(STEP_WORDS))
                           : (band_off + XW'(STEP_WORDS) < XW'(BAND_WORDS));
  assign src_word = down_q ? dst_word - XW'(STEP_WORDS) : dst_word + XW'(STEP_WORDS);

  assign in_ready = (seq_q == SEQ_IDLE) && !wr_pend_q && (!ov_q || out_o.ready);
  assign accept   = in_i.valid && in_ready;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = ov_q;
  assign out_o.payload = out_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_ANIM_MODE:   prdata = {29'd0, mode_q};
      REG_FRAME_DELAY: prdata = {24'd0, delay_q};
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    delay_d = delay_q;
    if (cfg_we) begin
      unique case (reg_e'(paddr[2]))
        REG_ANIM_MODE:   mode_d  = pwdata[2:0];
        REG_FRAME_DELAY: delay_d = pwdata[7:0];
      endcase
    end
  end

  // Sequencer
  always_comb begin
    seq_d       = seq_q;
    task_d      = task_q;
    cnt_d       = cnt_q;
    mix_d       = mix_q;
    off_d       = off_q;
    down_d      = down_q;
    rd_ok_d     = rd_ok_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_zero_d   = wr_zero_q;
    wr_from_a_d = wr_from_a_q;
    ov_d        = ov_q && !out_o.ready;
    out_d       = out_q;
    a_we        = 1'b0;
    a_raddr     = '0;
    b_raddr     = '0;
    load_res    = 1'b0;
    tv          = 1'b0;
    tl          = 8'd0;

    unique case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          load_res = 1'b1;
          unique case (in_i.payload.action)
            ACT_WRITE_A: a_we = idx_ok;
            ACT_START:   task_d = TASK_PENDING;
            ACT_READ_B: begin
              load_res = 1'b0;
              rd_ok_d  = idx_ok;
              b_raddr  = idx_addr;
              seq_d    = SEQ_READ;
            end
            ACT_TICK: begin
              if (task_q == TASK_PENDING) begin
                if (mode_q != MODE_NONE) begin
                  task_d = TASK_PLAYING;
                  cnt_d  = 8'd0;
                  tv     = 1'b1;
                  tl     = delay_q;
                  off_d  = '0;
                  seq_d  = SEQ_COPY;
                end else begin
                  task_d = TASK_IDLE;
                end
              end else if (task_q == TASK_PLAYING && in_i.payload.cyclic_display) begin
                tv = 1'b1;
                if ({1'b0, cnt_q} >= 9'(BAND_ROWS)) begin
                  task_d = TASK_IDLE;
                  mix_d  = MIX_A;
                end else begin
                  cnt_d = cnt_sum[8] ? 8'hFF : cnt_sum[7:0];
                  tl    = delay_q;
                  mix_d = MIX_B;
                  case (mode_q) inside
                    MODE_DOWN, MODE_UP: begin
                      down_d = (mode_q == MODE_DOWN);
                      off_d  = '0;
                      seq_d  = SEQ_SCROLL;
                    end
                    MODE_LEFT, MODE_RIGHT: ;
                    default: begin
                      task_d = TASK_IDLE;
                      mix_d  = MIX_A;
                    end
                  endcase
                end
              end
            end
          endcase
          if (load_res) begin
            ov_d  = 1'b1;
            out_d = '{read_word: 32'd0, mix_mode: mix_d, timer_load_valid: tv,
                      timer_load: tl, anim_state: task_d, frame_count: cnt_d};
          end
        end
      end
      SEQ_READ: begin
        ov_d  = 1'b1;
        out_d = '{read_word: (rd_ok_q ? b_rdata : 32'd0), mix_mode: mix_q,
                  timer_load_valid: 1'b0, timer_load: 8'd0, anim_state: task_q,
                  frame_count: cnt_q};
        seq_d = SEQ_IDLE;
      end
      SEQ_COPY: begin
        // Read A now, write the same word of B next cycle
        a_raddr     = off_q;
        wr_pend_d   = 1'b1;
        wr_addr_d   = off_q;
        wr_zero_d   = 1'b0;
        wr_from_a_d = 1'b1;
        off_d       = off_q + AW'(1);
        if (off_q == AW'(BUF_WORDS - 1)) begin
          seq_d = SEQ_IDLE;
        end
      end
      SEQ_SCROLL: begin
        // Reads always stay ahead of writes in walk order, so no hazard
        b_raddr     = src_word[AW-1:0];
        wr_pend_d   = 1'b1;
        wr_addr_d   = dst_word[AW-1:0];
        wr_zero_d   = !copy_ok;
        wr_from_a_d = 1'b0;
        off_d       = off_q + AW'(1);
        if (off_q == AW'(BAND_LAST)) begin
          seq_d = SEQ_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      task_q      <= TASK_IDLE;
      cnt_q       <= 8'd0;
      mix_q       <= MIX_A;
      mode_q      <= MODE_NONE;
      delay_q     <= 8'd0;
      off_q       <= '0;
      down_q      <= 1'b0;
      rd_ok_q     <= 1'b0;
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
      wr_zero_q   <= 1'b0;
      wr_from_a_q <= 1'b0;
      ov_q        <= 1'b0;
      out_q       <= '0;
    end else begin
      seq_q       <= seq_d;
      task_q      <= task_d;
      cnt_q       <= cnt_d;
      mix_q       <= mix_d;
      mode_q      <= mode_d;
      delay_q     <= delay_d;
      off_q       <= off_d;
      down_q      <= down_d;
      rd_ok_q     <= rd_ok_d;
      wr_pend_q   <= wr_pend_d;
      wr_addr_q   <= wr_addr_d;
      wr_zero_q   <= wr_zero_d;
      wr_from_a_q <= wr_from_a_d;
      ov_q        <= ov_d;
      out_q       <= out_d;
    end
  end

  `DMSA_ASSERT_NOW(a_busy_stall, wr_pend_q || seq_q != SEQ_IDLE, !in_i.ready, "item taken while busy")
  `DMSA_ASSERT_NOW(a_read_slot, seq_q == SEQ_READ, !ov_q, "result slot full when read data lands")
  `DMSA_ASSERT_NOW(a_scroll_range, seq_q == SEQ_SCROLL, {1'b0, off_q} < XW'(BAND_WORDS), "scroll walk past band")
  `DMSA_ASSERT_NOW(a_wr_range, wr_pend_q, {1'b0, wr_addr_q} < XW'(BUF_WORDS), "B write out of range")
  `DMSA_ASSERT_NEXT(a_copy_drain, seq_q == SEQ_COPY && seq_d == SEQ_IDLE, wr_pend_q, "last copy word not written")

endmodule

### sv/dmsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dmsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 800
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/sv/dot_matrix_scroll_animator_test.sv
// Self-checking bench for dot_matrix_scroll_animator: streams buffer and animation items,
// predicts every status record in lockstep and compares it against the output channel.
// Depends on dmsa_pkg, dmsa_stream_if and the RTL of the block.
`timescale 1ns / 1ps

module dot_matrix_scroll_animator_test;
  import dmsa_pkg::*;

  localparam int FRAME_ROWS  = FRAME_ROWS_DEF;
  localparam int ROW_WORDS   = ROW_WORDS_DEF;
  localparam int MARGIN_ROWS = MARGIN_ROWS_DEF;
  localparam int STEP_ROWS   = STEP_ROWS_DEF;
  localparam int BUF_WORDS   = FRAME_ROWS * ROW_WORDS;
  localparam int BAND_ROWS   = FRAME_ROWS - 2 * MARGIN_ROWS;

  localparam logic [2:0] REG_MODE_ADDR  = 3'd0;
  localparam logic [2:0] REG_DELAY_ADDR = 3'd4;

  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_DOWN  = 3'd1;
  localparam logic [2:0] MODE_UP    = 3'd2;
  localparam logic [2:0] MODE_LEFT  = 3'd3;
  localparam logic [2:0] MODE_RIGHT = 3'd4;
  localparam logic [2:0] MODE_RSV5  = 3'd5;
  localparam logic [2:0] MODE_RSV6  = 3'd6;
  localparam logic [2:0] MODE_RSV7  = 3'd7;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PENDING = 2'd1;
  localparam logic [1:0] PH_PLAYING = 2'd2;

  localparam logic [2:0] MIX_A = 3'd0;
  localparam logic [2:0] MIX_B = 3'd1;

  localparam logic [7:0] DELAY_MAX      = 8'd255;
  localparam int         PHASES         = 10;
  localparam int         PHASE_ITEMS    = 75;
  localparam int         SETTLE_CYCLES  = BUF_WORDS + 100;
  localparam int         WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dmsa_stream_if #(.payload_t(in_item_t))  in_ch ();
  dmsa_stream_if #(.payload_t(out_item_t)) out_ch ();

  logic        feed_valid = 1'b0;
  in_item_t    feed_item = '0;
  logic        take_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  assign in_ch.valid   = feed_valid;
  assign in_ch.payload = feed_item;
  assign out_ch.ready  = take_ready;

  dot_matrix_scroll_animator dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predicted animator state.
  logic [31:0] src_words [BUF_WORDS];
  logic [31:0] out_words [BUF_WORDS];
  logic [1:0]  task_phase = PH_IDLE;
  logic [7:0]  scroll_rows = '0;
  logic [2:0]  mix_sel = MIX_A;
  logic [2:0]  cfg_mode = MODE_NONE;
  logic [7:0]  cfg_delay = '0;

  in_item_t  item_backlog [$];
  out_item_t queued_status [$];
  int        fail_count = 0;

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want)
      report_failure($sformatf("%s expected 0x%08h, got 0x%08h", name, want, got));
  endtask

  function automatic void shift_band(input bit down);
    int r;
    for (int k = 0; k < BAND_ROWS; k++) begin
      // walk away from the side the band moves toward so no source row is overwritten
      if (down) begin
        r = MARGIN_ROWS + BAND_ROWS - 1 - k;
        for (int c = 0; c < ROW_WORDS; c++)
          out_words[r * ROW_WORDS + c] = (BAND_ROWS - 1 - k >= STEP_ROWS) ?
            out_words[(r - STEP_ROWS) * ROW_WORDS + c] : 32'd0;
      end else begin
        r = MARGIN_ROWS + k;
        for (int c = 0; c < ROW_WORDS; c++)
          out_words[r * ROW_WORDS + c] = (k + STEP_ROWS < BAND_ROWS) ?
            out_words[(r + STEP_ROWS) * ROW_WORDS + c] : 32'd0;
      end
    end
  endfunction

  function automatic void step_animator(input in_item_t it, output out_item_t res);
    int idx;
    int cnt;
    res = '0;
    idx = int'(it.word_index);
    case (it.action)
      ACT_WRITE_A: if (idx < BUF_WORDS) src_words[idx] = it.word_data;
      ACT_START:   task_phase = PH_PENDING;
      ACT_READ_B:  if (idx < BUF_WORDS) res.read_word = out_words[idx];
      ACT_TICK: begin
        if (task_phase == PH_PENDING) begin
          if (cfg_mode != MODE_NONE) begin
            task_phase = PH_PLAYING;
            scroll_rows = '0;
            res.timer_load_valid = 1'b1;
            res.timer_load = cfg_delay;
            out_words = src_words;
          end else begin
            task_phase = PH_IDLE;
          end
        end else if (task_phase == PH_PLAYING && it.cyclic_display) begin
          if (scroll_rows >= BAND_ROWS) begin
            task_phase = PH_IDLE;
            mix_sel = MIX_A;
            res.timer_load_valid = 1'b1;
            res.timer_load = '0;
          end else begin
            cnt = scroll_rows + STEP_ROWS;
            if (cnt > 255) cnt = 255;
            scroll_rows = cnt[7:0];
            res.timer_load_valid = 1'b1;
            res.timer_load = cfg_delay;
            mix_sel = MIX_B;
            case (cfg_mode)
              MODE_DOWN:              shift_band(1'b1);
              MODE_UP:                shift_band(1'b0);
              MODE_LEFT, MODE_RIGHT:  ;
              default: begin
                task_phase = PH_IDLE;
                mix_sel = MIX_A;
              end
            endcase
          end
        end
      end
    endcase
    res.mix_mode = mix_sel;
    res.anim_state = task_phase;
    res.frame_count = scroll_rows;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    out_item_t res;
    if (!rst_n) begin
      feed_valid <= 1'b0;
    end else begin
      if (feed_valid && in_ch.ready) begin
        step_animator(feed_item, res);
        queued_status.push_back(res);
      end
      if (!feed_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          feed_valid <= 1'b0;
        end else if (item_backlog.size() > 0) begin
          feed_item <= item_backlog.pop_front();
          feed_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          feed_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, checker and watchdog.
  int stall_left = 0;
  int calm_left = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      take_ready <= 1'b0;
    end else begin
      if (calm_left > 0) begin
        calm_left <= calm_left - 1;
        take_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
        case ($urandom_range(0, 15))
          0:       calm_left <= $urandom_range(50, 400);
          1, 2, 3: stall_left <= $urandom_range(1, 16);
          default: ;
        endcase
      end

      if (out_ch.valid && take_ready) begin
        got = out_ch.payload;
        if (queued_status.size() == 0) begin
          report_failure($sformatf("result 0x%0h arrived with nothing pending", got));
        end else begin
          want = queued_status.pop_front();
          check_field("read_word", want.read_word, got.read_word);
          check_field("mix_mode", 32'(want.mix_mode), 32'(got.mix_mode));
          check_field("timer_load_valid", 32'(want.timer_load_valid),
                      32'(got.timer_load_valid));
          check_field("timer_load", 32'(want.timer_load), 32'(got.timer_load));
          check_field("anim_state", 32'(want.anim_state), 32'(got.anim_state));
          check_field("frame_count", 32'(want.frame_count), 32'(got.frame_count));
        end
      end

      if ((feed_valid && in_ch.ready) || (out_ch.valid && take_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic bit all_drained();
    return item_backlog.size() == 0 && !feed_valid && queued_status.size() == 0;
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check(input logic [2:0] addr, input logic [31:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field($sformatf("register at 0x%0h", addr), want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_animation(input logic [2:0] mode, input logic [7:0] delay);
    apb_write(REG_MODE_ADDR, {29'd0, mode});
    apb_write(REG_DELAY_ADDR, {24'd0, delay});
    cfg_mode = mode;
    cfg_delay = delay;
    apb_check(REG_MODE_ADDR, {29'd0, mode});
    apb_check(REG_DELAY_ADDR, {24'd0, delay});
  endtask

  task automatic push_item(input action_e act, input int idx, input logic [31:0] data,
                           input bit cyc);
    in_item_t it;
    it.action = act;
    it.word_index = idx[9:0];
    it.word_data = data;
    it.cyclic_display = cyc;
    item_backlog.push_back(it);
  endtask

  function automatic int rand_index();
    return ($urandom_range(0, 6) == 0) ? $urandom_range(BUF_WORDS, 1023)
                                       : $urandom_range(0, BUF_WORDS - 1);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed animations (start, load tick, scroll ticks with reads mixed in),
  // the rest loose noise. The first run of a phase is usually long enough to play to its end.
  task automatic queue_phase(input int count);
    int  pushed;
    int  len;
    bit  first;
    pushed = 0;
    first = 1'b1;
    while (pushed < count) begin
      if (first || $urandom_range(0, 9) < 7) begin
        len = first ? 40 : (($urandom_range(0, 3) == 0) ? $urandom_range(33, 38)
                                                        : $urandom_range(1, 10));
        repeat ($urandom_range(0, 2)) begin
          push_item(ACT_WRITE_A, rand_index(), rand_word(), 1'($urandom_range(0, 1)));
          pushed++;
        end
        push_item(ACT_START, rand_index(), rand_word(), 1'($urandom_range(0, 1)));
        push_item(ACT_TICK, rand_index(), rand_word(), 1'($urandom_range(0, 1)));
        pushed += 2;
        repeat (len) begin
          push_item(ACT_TICK, rand_index(), rand_word(), $urandom_range(0, 9) != 0);
          pushed++;
          if ($urandom_range(0, 2) == 0) begin
            push_item(ACT_READ_B, rand_index(), rand_word(), 1'($urandom_range(0, 1)));
            pushed++;
          end
          if ($urandom_range(0, 11) == 0) begin
            push_item(ACT_WRITE_A, rand_index(), rand_word(), 1'($urandom_range(0, 1)));
            pushed++;
          end
          if (!first && $urandom_range(0, 59) == 0) begin
            push_item(ACT_START, rand_index(), rand_word(), 1'($urandom_range(0, 1)));
            pushed++;
          end
        end
        first = 1'b0;
      end else begin
        repeat ($urandom_range(1, 5)) begin
          push_item(action_e'($urandom_range(0, 3)), rand_index(), rand_word(),
                    1'($urandom_range(0, 1)));
          pushed++;
        end
      end
    end
  endtask

  initial begin
    logic [2:0] mode;
    logic [7:0] delay;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_animation(MODE_DOWN, DELAY_MAX);

    // Fill all of A so that every later load of B copies written words only.
    push_item(ACT_WRITE_A, 0, 32'hFFFF_FFFF, 1'b0);
    push_item(ACT_WRITE_A, 1, 32'd0, 1'b1);
    for (int i = 2; i < BUF_WORDS; i++) push_item(ACT_WRITE_A, i, $urandom, 1'b0);

    // Out-of-range accesses, idle tick, double start, load outside cyclic display.
    push_item(ACT_WRITE_A, 1023, 32'hFFFF_FFFF, 1'b1);
    push_item(ACT_WRITE_A, BUF_WORDS, 32'hA5A5_A5A5, 1'b0);
    push_item(ACT_READ_B, BUF_WORDS, 32'd0, 1'b0);
    push_item(ACT_READ_B, 1023, 32'hFFFF_FFFF, 1'b1);
    push_item(ACT_TICK, 0, 32'd0, 1'b1);
    push_item(ACT_START, 0, 32'd0, 1'b0);
    push_item(ACT_START, 1023, 32'hFFFF_FFFF, 1'b1);
    push_item(ACT_TICK, 0, 32'd0, 1'b0);
    push_item(ACT_READ_B, 0, 32'd0, 1'b0);
    push_item(ACT_READ_B, BUF_WORDS - 1, 32'd0, 1'b0);
    push_item(ACT_READ_B, MARGIN_ROWS * ROW_WORDS, 32'd0, 1'b0);
    // Playing tick outside cyclic display, then one scroll and probes around the band.
    push_item(ACT_TICK, 0, 32'd0, 1'b0);
    push_item(ACT_TICK, 0, 32'd0, 1'b1);
    push_item(ACT_READ_B, MARGIN_ROWS * ROW_WORDS, 32'd0, 1'b0);
    push_item(ACT_READ_B, (MARGIN_ROWS + STEP_ROWS) * ROW_WORDS, 32'd0, 1'b0);
    push_item(ACT_READ_B, (FRAME_ROWS - MARGIN_ROWS) * ROW_WORDS - 1, 32'd0, 1'b0);
    push_item(ACT_READ_B, (FRAME_ROWS - MARGIN_ROWS) * ROW_WORDS, 32'd0, 1'b0);
    // Restart while playing reloads B from A.
    push_item(ACT_WRITE_A, 0, 32'd0, 1'b0);
    push_item(ACT_START, 0, 32'd0, 1'b1);
    push_item(ACT_TICK, 0, 32'd0, 1'b1);
    push_item(ACT_READ_B, 0, 32'd0, 1'b1);
    push_item(ACT_TICK, 0, 32'd0, 1'b1);
    push_item(ACT_READ_B, 1023, 32'd0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      // hold the sender until every result is in and the block has gone quiet
      while (!all_drained()) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        0:       mode = MODE_UP;
        1:       mode = MODE_NONE;
        2:       mode = MODE_LEFT;
        3:       mode = MODE_RSV5;
        4:       mode = MODE_DOWN;
        5:       mode = MODE_RIGHT;
        6:       mode = MODE_RSV6;
        7:       mode = MODE_UP;
        8:       mode = MODE_RSV7;
        default: mode = MODE_DOWN;
      endcase
      if (p == 0) delay = 8'd0;
      else if (p == PHASES - 1) delay = DELAY_MAX;
      else delay = $urandom_range(1, 254);
      set_animation(mode, delay);
      queue_phase(PHASE_ITEMS);
    end

    while (!all_drained()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (queued_status.size() != 0) report_failure("results still pending at the end");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
